### design/mmul_pkg.sv
// ----------------------------------------------------------------------------
// mmul_pkg
// Shared codes, fixed field widths and the controller-to-datapath command
// bundle of the matrix multiplier.
// ----------------------------------------------------------------------------
package mmul_pkg;

  // Fixed field widths of the request and configuration ports
  localparam int OPCODE_W  = 2;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

  // Reset value of every dimension register
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

  // Command from controller to datapath, valid for the current cycle
  typedef struct packed {
    logic wr_a;     // write A element at the request address
    logic wr_b;     // write B element at the request address
    logic err;      // emit an out-of-range error result
    logic step;     // issue one multiply-accumulate step
    logic first;    // step opens a new dot product
    logic dot_end;  // step closes the dot product
    logic run_end;  // step closes the whole product matrix
  } mmul_cmd_t;

endpackage

### design/mmul_ctrl.sv
// ----------------------------------------------------------------------------
// mmul_ctrl
// Controller: holds the dimension registers, checks load addresses and walks
// the row, column and inner-product counters of a compute run.
// ----------------------------------------------------------------------------
module mmul_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mmul_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [mmul_pkg::IDX_W-1:0]        in_row_index,
  input  logic [mmul_pkg::IDX_W-1:0]        in_col_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmul_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmul_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              pipe_busy,
  output logic                              busy,
  output mmul_pkg::mmul_cmd_t               cmd,
  output logic [$clog2(MAX_DIM)-1:0]        step_row,
  output logic [$clog2(MAX_DIM)-1:0]        step_col,
  output logic [$clog2(MAX_DIM)-1:0]        step_k
);
  import mmul_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] a_rows_r, inner_dim_r, b_cols_r;
  logic [DIM_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CMP_W-1:0] m_eff, n_eff, p_eff;
  logic [CMP_W-1:0] row_ext, col_ext;
  logic             a_ok, b_ok;
  logic             i_last, j_last, k_last;

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [CMP_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [CMP_W-1:0] v;
    v = CMP_W'(r);
    if (v == '0) return CMP_W'(1);
    if (v > CMP_W'(MAX_DIM)) return CMP_W'(MAX_DIM);
    return v;
  endfunction

  assign cfg_ready = 1'b1;

  // Dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r    <= CFG_DIM_RESET;
      inner_dim_r <= CFG_DIM_RESET;
      b_cols_r    <= CFG_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_A_ROWS:    a_rows_r    <= cfg_data;
        REG_INNER_DIM: inner_dim_r <= cfg_data;
        REG_B_COLS:    b_cols_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m_eff = eff_dim(a_rows_r);
  assign n_eff = eff_dim(inner_dim_r);
  assign p_eff = eff_dim(b_cols_r);

  // Load address range checks
  assign row_ext = CMP_W'(in_row_index);
  assign col_ext = CMP_W'(in_col_index);
  assign a_ok    = (row_ext < m_eff) && (col_ext < n_eff);
  assign b_ok    = (row_ext < n_eff) && (col_ext < p_eff);

  // Counter wrap points
  assign i_last = CMP_W'(i_r) == (m_eff - CMP_W'(1));
  assign j_last = CMP_W'(j_r) == (p_eff - CMP_W'(1));
  assign k_last = CMP_W'(k_r) == (n_eff - CMP_W'(1));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_LOAD_A: begin
              cmd.wr_a = a_ok;
              cmd.err  = !a_ok;
            end
            OP_LOAD_B: begin
              cmd.wr_b = b_ok;
              cmd.err  = !b_ok;
            end
            OP_COMPUTE: begin
              state_nxt = ST_RUN;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.step    = 1'b1;
        cmd.first   = (k_r == '0);
        cmd.dot_end = k_last;
        cmd.run_end = i_last && j_last && k_last;
        if (k_last) begin
          k_nxt = '0;
          if (j_last) begin
            j_nxt = '0;
            i_nxt = i_r + DIM_W'(1);
          end else begin
            j_nxt = j_r + DIM_W'(1);
          end
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
        if (i_last && j_last && k_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign step_row = i_r;
  assign step_col = j_r;
  assign step_k   = k_r;

  // Counters never leave the configured matrix during a run
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((CMP_W'(i_r) < m_eff) && (CMP_W'(j_r) < p_eff) &&
                             (CMP_W'(k_r) < n_eff)))
    else $error("mmul_ctrl: run counter outside configured size");

  // A dot product is issued without gaps
  a_dot_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !cmd.dot_end) |=> (cmd.step && !cmd.first))
    else $error("mmul_ctrl: dot product interrupted");

  // The final step hands over to the drain phase
  a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_end |=> (state_r == ST_DRAIN && pipe_busy))
    else $error("mmul_ctrl: run end did not enter drain");

endmodule

### design/mmul_dp.sv
// ----------------------------------------------------------------------------
// mmul_dp
// Datapath: A and B element stores, multiply-accumulate pipeline, rounding and
// saturation to the element format, and the result register.
// ----------------------------------------------------------------------------
module mmul_dp #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmul_pkg::mmul_cmd_t           cmd,
  input  logic [$clog2(MAX_DIM)-1:0]    step_row,
  input  logic [$clog2(MAX_DIM)-1:0]    step_col,
  input  logic [$clog2(MAX_DIM)-1:0]    step_k,
  input  logic [mmul_pkg::IDX_W-1:0]    in_row_index,
  input  logic [mmul_pkg::IDX_W-1:0]    in_col_index,
  input  logic signed [ELEM_WIDTH-1:0]  in_elem_value,
  output logic                          pipe_busy,
  output logic                          out_valid,
  output logic signed [ELEM_WIDTH-1:0]  out_prod_value,
  output logic [mmul_pkg::IDX_W-1:0]    out_row,
  output logic [mmul_pkg::IDX_W-1:0]    out_col,
  output logic                          out_last_flag,
  output logic                          out_error_flag
);
  import mmul_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FRAC   = ELEM_WIDTH / 2;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
  localparam int RND_W  = ACC_W + 1;
  localparam int SH_W   = RND_W - FRAC;
  localparam logic [RND_W-1:0] HALF_LSB = RND_W'(1) << (FRAC - 1);

  typedef struct packed {
    logic             vld;
    logic             first;
    logic             dot_end;
    logic             run_end;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } mmul_tag_t;

  logic [ELEM_WIDTH-1:0]        a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0]        b_mem [DEPTH];
  logic [ADDR_W-1:0]            ld_addr, a_rd_addr, b_rd_addr;
  logic signed [ELEM_WIDTH-1:0] a_rd_r, b_rd_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt, prod_ext;
  mmul_tag_t                    s1_nxt, s1_r, s2_r, s3_r;
  logic [RND_W-1:0]             rnd;
  logic [SH_W-1:0]              shr;
  logic [SH_W-ELEM_WIDTH:0]     top_bits;
  logic [ELEM_WIDTH-1:0]        sat;
  logic                         emit;

  logic                         out_valid_r;
  logic [ELEM_WIDTH-1:0]        out_value_r;
  logic [IDX_W-1:0]             out_row_r, out_col_r;
  logic                         out_last_r, out_err_r;

  // Element addresses, row-major with MAX_DIM columns
  assign ld_addr   = ADDR_W'(DIM_W'(in_row_index)) * ADDR_W'(MAX_DIM) +
                     ADDR_W'(DIM_W'(in_col_index));
  assign a_rd_addr = ADDR_W'(step_row) * ADDR_W'(MAX_DIM) + ADDR_W'(step_k);
  assign b_rd_addr = ADDR_W'(step_k) * ADDR_W'(MAX_DIM) + ADDR_W'(step_col);

  // Element stores, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_a) a_mem[ld_addr] <= in_elem_value;
    a_rd_r <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) b_mem[ld_addr] <= in_elem_value;
    b_rd_r <= b_mem[b_rd_addr];
  end

  // Step tags travel alongside the data
  always_comb begin
    s1_nxt.vld     = cmd.step;
    s1_nxt.first   = cmd.first;
    s1_nxt.dot_end = cmd.dot_end;
    s1_nxt.run_end = cmd.run_end;
    s1_nxt.row     = step_row;
    s1_nxt.col     = step_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  assign pipe_busy = s1_r.vld || s2_r.vld || s3_r.vld;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
  end

  // Accumulate stage, restart on the first term of each dot product
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = s2_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (s2_r.vld) acc_r <= acc_nxt;
  end

  // Round half up, drop fraction bits, saturate to the element range
  assign rnd      = {acc_r[ACC_W-1], acc_r} + HALF_LSB;
  assign shr      = rnd[RND_W-1:FRAC];
  assign top_bits = shr[SH_W-1:ELEM_WIDTH-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sat = shr[ELEM_WIDTH-1:0];
    end else if (shr[SH_W-1]) begin
      sat = {1'b1, {(ELEM_WIDTH - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
    end
  end

  assign emit = s3_r.vld && s3_r.dot_end;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit || cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      out_value_r <= '0;
      out_row_r   <= in_row_index;
      out_col_r   <= in_col_index;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end else if (emit) begin
      out_value_r <= sat;
      out_row_r   <= IDX_W'(s3_r.row);
      out_col_r   <= IDX_W'(s3_r.col);
      out_last_r  <= s3_r.run_end;
      out_err_r   <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prod_value = out_value_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_last_flag  = out_last_r;
  assign out_error_flag = out_err_r;

  // Error results never meet a product result in the result register
  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit && cmd.err))
    else $error("mmul_dp: error and product result collide");

  // A continuing term always follows a term of the same dot product
  a_acc_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_r.vld && !s2_r.first) |-> (s3_r.vld && !s3_r.dot_end))
    else $error("mmul_dp: accumulation without open dot product");

  // A new dot product starts only after the previous one closed
  a_acc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.vld && s1_r.first && s2_r.vld) |-> s2_r.dot_end)
    else $error("mmul_dp: dot product restarted before it closed");

endmodule

### design/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// Signed fixed-point matrix multiplier P = A x B with element stores, a
// sequencing controller and a multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Loads of A or B
// elements may follow back to back; a load outside the configured sizes
// returns one error result in the cycle right after it is taken. A compute
// request holds busy while the single multiply-accumulate unit does one
// product term per cycle behind a store read and a multiply stage, and until
// the pipeline drains; product elements come out in row-major order, one per
// dot product, and the last one is on the ports in the cycle before busy
// drops. Results are shown for exactly one cycle on out_valid and cannot be
// held off, so the receiver must take every one. Configuration writes are
// always ready and must only be made while busy is low.
module matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mmul_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [mmul_pkg::IDX_W-1:0]        in_row_index,
  input  logic [mmul_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [ELEM_WIDTH-1:0]      in_elem_value,
  output logic                              out_valid,
  output logic signed [ELEM_WIDTH-1:0]      out_prod_value,
  output logic [mmul_pkg::IDX_W-1:0]        out_row,
  output logic [mmul_pkg::IDX_W-1:0]        out_col,
  output logic                              out_last_flag,
  output logic                              out_error_flag,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmul_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmul_pkg::CFG_W-1:0]        cfg_data
);
  import mmul_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM);

  mmul_cmd_t        cmd;
  logic             pipe_busy;
  logic [DIM_W-1:0] step_row, step_col, step_k;

  // Controller
  mmul_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_opcode    (in_opcode),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pipe_busy    (pipe_busy),
    .busy         (busy),
    .cmd          (cmd),
    .step_row     (step_row),
    .step_col     (step_col),
    .step_k       (step_k)
  );

  // Datapath
  mmul_dp #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .step_row       (step_row),
    .step_col       (step_col),
    .step_k         (step_k),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_elem_value  (in_elem_value),
    .pipe_busy      (pipe_busy),
    .out_valid      (out_valid),
    .out_prod_value (out_prod_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_last_flag  (out_last_flag),
    .out_error_flag (out_error_flag)
  );

endmodule
